@@ rtl/cubic_curve_point_generator_macros.svh @@
// Assertion macros shared by the checker.
`ifndef CUBIC_CURVE_POINT_GENERATOR_MACROS_SVH
`define CUBIC_CURVE_POINT_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCPG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ccpg_pkg.sv @@
package ccpg_pkg;

  localparam int unsigned PixW    = 16;
  localparam int unsigned CountW  = 7;
  localparam int unsigned GainW   = 16;
  localparam int unsigned DiffW   = PixW + 1;
  localparam int unsigned CoeffW  = 40;
  localparam int unsigned TW      = 17;   // t in 16 fraction bits, up to exactly 1.0
  localparam int unsigned TFracW  = 16;
  localparam int unsigned FracW   = 12;   // coefficient fraction bits
  localparam int unsigned ProdW   = CoeffW + TW + 1;

  localparam logic [CountW-1:0] PointCountRst = 7'd64;
  localparam logic [GainW-1:0]  ShapeGainRst  = 16'd12288;
  localparam logic [CountW-1:0] MinPoints     = 7'd2;

  // register map
  localparam logic CfgPointCount = 1'b0;
  localparam logic CfgShapeGain  = 1'b1;

  // coefficient store slots
  localparam logic [2:0] CoefAx = 3'd0;
  localparam logic [2:0] CoefBx = 3'd1;
  localparam logic [2:0] CoefCx = 3'd2;
  localparam logic [2:0] CoefAy = 3'd3;
  localparam logic [2:0] CoefBy = 3'd4;
  localparam logic [2:0] CoefCy = 3'd5;

  typedef struct packed {
    logic signed [PixW-1:0] start_x;
    logic signed [PixW-1:0] start_y;
    logic signed [PixW-1:0] pull1_x;
    logic signed [PixW-1:0] pull1_y;
    logic signed [PixW-1:0] pull2_x;
    logic signed [PixW-1:0] pull2_y;
    logic signed [PixW-1:0] end_x;
    logic signed [PixW-1:0] end_y;
  } in_word_t;

  typedef struct packed {
    logic signed [PixW-1:0] point_x;
    logic signed [PixW-1:0] point_y;
    logic                   last_point;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP0,
    ST_SETUP1,
    ST_SETUP2,
    ST_SETUP3,
    ST_SETUP4,
    ST_WAIT_DIV,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_H4,
    ST_H5,
    ST_H6,
    ST_H7,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_D1X,
    MUL_D2X,
    MUL_D1Y,
    MUL_D2Y,
    MUL_SX,
    MUL_SY
  } mul_src_e;

  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_CX,
    ACC_ABX,
    ACC_CY,
    ACC_ABY,
    ACC_LOAD_A,
    ACC_HX_B,
    ACC_HY_B,
    ACC_HX_C,
    ACC_HY_C,
    ACC_HX_O,
    ACC_HY_O
  } acc_op_e;

  typedef struct packed {
    logic     load_item;
    mul_src_e mul_src;
    acc_op_e  acc_op;
    logic     out_load;
    logic     t_step;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
    logic out_free;
  } status_t;

endpackage

@@ rtl/ccpg_tdiv.sv @@
module ccpg_tdiv #(
  parameter int unsigned IdxW = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [IdxW-1:0]            divisor_i,
  output logic                       busy_o,
  output logic [ccpg_pkg::TW-1:0]    quot_o,
  output logic [IdxW-1:0]            rem_o
);
  import ccpg_pkg::*;

  // 2^16 / divisor, one quotient bit per cycle, MSB first
  localparam int unsigned CntW = $clog2(TW);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] div_q;
  logic [IdxW-1:0] rem_q, rem_d;
  logic [TW-1:0]   quot_q, quot_d;
  logic [IdxW:0]   trial;
  logic            ge;

  always_comb begin
    trial  = {rem_q, (cnt_q == CntW'(TFracW))};
    ge     = (trial >= {1'b0, div_q});
    rem_d  = ge ? IdxW'(trial - {1'b0, div_q}) : trial[IdxW-1:0];
    quot_d = {quot_q[TW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(TW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/ccpg_ctrl.sv @@
module ccpg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ccpg_pkg::status_t status_i,
  output ccpg_pkg::cmd_t    cmd_o
);
  import ccpg_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_SETUP0;
      ST_SETUP0:   state_d = ST_SETUP1;
      ST_SETUP1:   state_d = ST_SETUP2;
      ST_SETUP2:   state_d = ST_SETUP3;
      ST_SETUP3:   state_d = ST_SETUP4;
      ST_SETUP4:   state_d = ST_WAIT_DIV;
      ST_WAIT_DIV: if (status_i.div_done) state_d = ST_H1;
      ST_H1:       state_d = ST_H2;
      ST_H2:       state_d = ST_H3;
      ST_H3:       state_d = ST_H4;
      ST_H4:       state_d = ST_H5;
      ST_H5:       state_d = ST_H6;
      ST_H6:       state_d = ST_H7;
      ST_H7:       state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.last ? ST_IDLE : ST_H1;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.load_item = 1'b0;
    cmd_o.mul_src   = MUL_NONE;
    cmd_o.acc_op    = ACC_NONE;
    cmd_o.out_load  = 1'b0;
    cmd_o.t_step    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_SETUP0: cmd_o.mul_src = MUL_D1X;
      ST_SETUP1: begin
        cmd_o.mul_src = MUL_D2X;
        cmd_o.acc_op  = ACC_CX;
      end
      ST_SETUP2: begin
        cmd_o.mul_src = MUL_D1Y;
        cmd_o.acc_op  = ACC_ABX;
      end
      ST_SETUP3: begin
        cmd_o.mul_src = MUL_D2Y;
        cmd_o.acc_op  = ACC_CY;
      end
      ST_SETUP4: cmd_o.acc_op = ACC_ABY;
      ST_WAIT_DIV: begin
        if (status_i.div_done) cmd_o.acc_op = ACC_LOAD_A;
      end
      ST_H1: cmd_o.mul_src = MUL_SX;
      ST_H2: begin
        cmd_o.mul_src = MUL_SY;
        cmd_o.acc_op  = ACC_HX_B;
      end
      ST_H3: begin
        cmd_o.mul_src = MUL_SX;
        cmd_o.acc_op  = ACC_HY_B;
      end
      ST_H4: begin
        cmd_o.mul_src = MUL_SY;
        cmd_o.acc_op  = ACC_HX_C;
      end
      ST_H5: begin
        cmd_o.mul_src = MUL_SX;
        cmd_o.acc_op  = ACC_HY_C;
      end
      ST_H6: begin
        cmd_o.mul_src = MUL_SY;
        cmd_o.acc_op  = ACC_HX_O;
      end
      ST_H7: cmd_o.acc_op = ACC_HY_O;
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (!status_i.last) begin
            cmd_o.t_step = 1'b1;
            cmd_o.acc_op = ACC_LOAD_A;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/ccpg_datapath.sv @@
module ccpg_datapath #(
  parameter int unsigned MaxPoints = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ccpg_pkg::cmd_t                  cmd_i,
  output ccpg_pkg::status_t               status_o,
  input  ccpg_pkg::in_word_t              in_word_i,
  input  logic [ccpg_pkg::CountW-1:0]     point_count_i,
  input  logic [ccpg_pkg::GainW-1:0]      shape_gain_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ccpg_pkg::out_word_t             out_word_o
);
  import ccpg_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam logic [CountW-1:0] MaxN = CountW'(MaxPoints);

  // item registers
  logic signed [DiffW-1:0]  d1x_q, d2x_q, d3x_q, d1y_q, d2y_q, d3y_q;
  logic signed [PixW-1:0]   org_q [2];
  logic [GainW-1:0]         gain_q;
  logic [IdxW-1:0]          d_q;

  logic signed [CoeffW-1:0] coeff_q [6];
  logic signed [CoeffW-1:0] sx_q, sy_q;
  logic signed [ProdW-1:0]  prod_q, prod_d;

  logic [TW-1:0]            t_q;
  logic [IdxW-1:0]          r_q;
  logic [IdxW-1:0]          idx_q;

  logic                     out_valid_q;
  out_word_t                out_q;

  logic                     div_busy;
  logic [TW-1:0]            step_q0;
  logic [IdxW-1:0]          step_r0;

  logic [CountW-1:0]        n_sel;
  logic [IdxW-1:0]          d_in;
  logic signed [CoeffW-1:0] a_op;
  logic [TW-1:0]            b_op;
  logic signed [CoeffW-1:0] prod_lo, prod_tr;
  logic                     prod_fix;
  logic signed [CoeffW-1:0] d3x_sh, d3y_sh, orgx_sh, orgy_sh;
  logic [IdxW:0]            r_sum;
  logic                     r_wrap;

  // truncate toward zero by 2^12, then clamp to 16 bits
  function automatic logic [PixW-1:0] round_sat(input logic signed [CoeffW-1:0] s);
    logic signed [CoeffW-FracW-1:0] q;
    logic                           fix;
    fix = s[CoeffW-1] & (|s[FracW-1:0]);
    q   = s[CoeffW-1:FracW] + {{(CoeffW-FracW-1){1'b0}}, fix};
    if (q > (CoeffW-FracW)'(32767)) begin
      return 16'h7fff;
    end else if (q < -(CoeffW-FracW)'(32768)) begin
      return 16'h8000;
    end else begin
      return q[PixW-1:0];
    end
  endfunction

  // divisor is the clamped point count less one
  always_comb begin
    if (point_count_i < MinPoints) begin
      n_sel = MinPoints;
    end else if (point_count_i > MaxN) begin
      n_sel = MaxN;
    end else begin
      n_sel = point_count_i;
    end
    d_in = IdxW'(n_sel - 1'b1);
  end

  ccpg_tdiv #(
    .IdxW (IdxW)
  ) u_tdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.load_item),
    .divisor_i (d_in),
    .busy_o    (div_busy),
    .quot_o    (step_q0),
    .rem_o     (step_r0)
  );

  // shared multiplier, signed 40 x unsigned 17
  always_comb begin
    a_op = sx_q;
    b_op = t_q;
    case (cmd_i.mul_src)
      MUL_D1X: begin a_op = CoeffW'(d1x_q); b_op = {1'b0, gain_q}; end
      MUL_D2X: begin a_op = CoeffW'(d2x_q); b_op = {1'b0, gain_q}; end
      MUL_D1Y: begin a_op = CoeffW'(d1y_q); b_op = {1'b0, gain_q}; end
      MUL_D2Y: begin a_op = CoeffW'(d2y_q); b_op = {1'b0, gain_q}; end
      MUL_SY:  a_op = sy_q;
      default: a_op = sx_q;
    endcase
    prod_d = a_op * $signed({1'b0, b_op});
  end

  always_comb begin
    prod_lo  = prod_q[CoeffW-1:0];
    prod_fix = prod_q[ProdW-1] & (|prod_q[TFracW-1:0]);
    prod_tr  = prod_q[CoeffW+TFracW-1:TFracW] + {{(CoeffW-1){1'b0}}, prod_fix};
    d3x_sh   = {{(CoeffW-DiffW-FracW){d3x_q[DiffW-1]}}, d3x_q, {FracW{1'b0}}};
    d3y_sh   = {{(CoeffW-DiffW-FracW){d3y_q[DiffW-1]}}, d3y_q, {FracW{1'b0}}};
    orgx_sh  = {{(CoeffW-PixW-FracW){org_q[0][PixW-1]}}, org_q[0], {FracW{1'b0}}};
    orgy_sh  = {{(CoeffW-PixW-FracW){org_q[1][PixW-1]}}, org_q[1], {FracW{1'b0}}};
    r_sum    = {1'b0, r_q} + {1'b0, step_r0};
    r_wrap   = (r_sum >= {1'b0, d_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      d1x_q    <= {in_word_i.pull1_x[PixW-1], in_word_i.pull1_x}
                - {in_word_i.start_x[PixW-1], in_word_i.start_x};
      d2x_q    <= {in_word_i.pull2_x[PixW-1], in_word_i.pull2_x}
                - {in_word_i.pull1_x[PixW-1], in_word_i.pull1_x};
      d3x_q    <= {in_word_i.end_x[PixW-1], in_word_i.end_x}
                - {in_word_i.start_x[PixW-1], in_word_i.start_x};
      d1y_q    <= {in_word_i.pull1_y[PixW-1], in_word_i.pull1_y}
                - {in_word_i.start_y[PixW-1], in_word_i.start_y};
      d2y_q    <= {in_word_i.pull2_y[PixW-1], in_word_i.pull2_y}
                - {in_word_i.pull1_y[PixW-1], in_word_i.pull1_y};
      d3y_q    <= {in_word_i.end_y[PixW-1], in_word_i.end_y}
                - {in_word_i.start_y[PixW-1], in_word_i.start_y};
      org_q[0] <= in_word_i.start_x;
      org_q[1] <= in_word_i.start_y;
      gain_q   <= shape_gain_i;
      d_q      <= d_in;
    end

    if (cmd_i.mul_src != MUL_NONE) begin
      prod_q <= prod_d;
    end

    case (cmd_i.acc_op)
      ACC_CX:  coeff_q[CoefCx] <= prod_lo;
      ACC_ABX: begin
        coeff_q[CoefBx] <= prod_lo - coeff_q[CoefCx];
        coeff_q[CoefAx] <= d3x_sh - prod_lo;
      end
      ACC_CY:  coeff_q[CoefCy] <= prod_lo;
      ACC_ABY: begin
        coeff_q[CoefBy] <= prod_lo - coeff_q[CoefCy];
        coeff_q[CoefAy] <= d3y_sh - prod_lo;
      end
      ACC_LOAD_A: begin
        sx_q <= coeff_q[CoefAx];
        sy_q <= coeff_q[CoefAy];
      end
      ACC_HX_B: sx_q <= prod_tr + coeff_q[CoefBx];
      ACC_HY_B: sy_q <= prod_tr + coeff_q[CoefBy];
      ACC_HX_C: sx_q <= prod_tr + coeff_q[CoefCx];
      ACC_HY_C: sy_q <= prod_tr + coeff_q[CoefCy];
      ACC_HX_O: sx_q <= prod_tr + orgx_sh;
      ACC_HY_O: sy_q <= prod_tr + orgy_sh;
      default: ;
    endcase

    // t = floor(i * 2^16 / d), stepped by quotient and remainder
    if (cmd_i.load_item) begin
      t_q <= '0;
      r_q <= '0;
    end else if (cmd_i.t_step) begin
      if (r_wrap) begin
        r_q <= IdxW'(r_sum - {1'b0, d_q});
        t_q <= t_q + step_q0 + 1'b1;
      end else begin
        r_q <= r_sum[IdxW-1:0];
        t_q <= t_q + step_q0;
      end
    end

    if (cmd_i.out_load) begin
      out_q.point_x    <= round_sat(sx_q);
      out_q.point_y    <= round_sat(sy_q);
      out_q.last_point <= (idx_q == d_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_item) begin
        idx_q <= '0;
      end else if (cmd_i.t_step) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.div_done = !div_busy;
  assign status_o.last     = (idx_q == d_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ rtl/cubic_curve_point_generator.sv @@
// Cubic curve point generator: n points per set of four control points.
// One input word is processed at a time; each point word waits for a free output register.
// Points share one 40x17 multiplier, with x and y interleaved.
// Reset (rst_ni, async, active low): idle, output empty, point_count = 64,
//   shape_gain = 3.0; coefficient and origin registers are not cleared.
module cubic_curve_point_generator #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ccpg_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ccpg_pkg::out_word_t           out_word_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [ccpg_pkg::GainW-1:0]    cfg_wdata_i
);
  import ccpg_pkg::*;

  // Configuration registers. Writes should land only while idle; the user must ensure this, as the block
  // does not enforce it. The datapath samples them once per input word, at acceptance.
  logic [CountW-1:0] point_count_q;
  logic [GainW-1:0]  shape_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= PointCountRst;
      shape_gain_q  <= ShapeGainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgPointCount: point_count_q <= cfg_wdata_i[CountW-1:0];
        CfgShapeGain:  shape_gain_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Controller sequences one word at a time:
  //   setup    - k*(P1-P0), k*(P2-P1) per axis through the shared multiplier,
  //              giving c, b and a; the 2^16/(n-1) step divider runs alongside.
  //   per point - three Horner steps on x and y, interleaved so the registered
  //              product of one axis is folded in while the other multiplies,
  //              then P0 is added back and the result rounded toward zero.
  //   emit     - point goes into the output register when free; t and index step unless last.
  // The output register lets the next word be taken while the last point waits.
  cmd_t    cmd;
  status_t status;

  ccpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ccpg_datapath #(
    .MaxPoints (MAX_POINTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_word_i     (in_word_i),
    .point_count_i (point_count_q),
    .shape_gain_i  (shape_gain_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_word_o    (out_word_o)
  );

endmodule

@@ rtl/ccpg_checker.sv @@
`include "cubic_curve_point_generator_macros.svh"

module ccpg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ccpg_pkg::out_word_t out_word_i
);

  // a stalled point word holds
  `CCPG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_word_i), "point word changed while stalled")

  // one word at a time: taking a word drops ready
  `CCPG_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "ready stayed high after a word was taken")

  // no point can appear straight after a word is taken
  `CCPG_ASSERT_NEXT(a_no_early_point, clk_i, rst_ni, in_valid_i && in_ready_i, !$rose(out_valid_i), "point word right after input")

  // ready returns only together with the final point of the run
  `CCPG_ASSERT_SAME(a_ready_on_last, clk_i, rst_ni, $rose(in_ready_i), out_valid_i && out_word_i.last_point, "ready rose without the final point")

endmodule

bind cubic_curve_point_generator ccpg_checker u_ccpg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_i  (out_word_o)
);
